FILE: hdl/hdcn_pkg.sv
`timescale 1ns / 1ps

package hdcn_pkg;

   localparam logic [2:0] ACT_CONNECT    = 3'd0;
   localparam logic [2:0] ACT_DISCONNECT = 3'd1;
   localparam logic [2:0] ACT_SET_WANTED = 3'd2;
   localparam logic [2:0] ACT_REQUEST    = 3'd3;
   localparam logic [2:0] ACT_ACCEPTED   = 3'd4;
   localparam logic [2:0] ACT_REPORT     = 3'd5;

   localparam logic [1:0] KIND_NONE = 2'd0;
   localparam logic [1:0] KIND_GET  = 2'd1;
   localparam logic [1:0] KIND_SET  = 2'd2;

   localparam logic [7:0] CSR_SHORT_ID   = 8'd0;
   localparam logic [7:0] CSR_LONG_ID    = 8'd1;
   localparam logic [7:0] CSR_FEATURE_ID = 8'd2;
   localparam logic [7:0] CSR_CONTROL_ID = 8'd3;

   localparam logic [7:0] DEV_INDEX        = 8'hff;
   localparam logic [7:0] SW_ID            = 8'h02;
   localparam logic [7:0] ROOT_INDEX       = 8'h00;
   localparam logic [3:0] SET_REPORTING_FN = 4'd3;
   localparam logic [7:0] FLAGS_ON         = 8'h03;
   localparam logic [7:0] FLAGS_OFF        = 8'h02;
   localparam logic [7:0] ERR_MARK         = 8'hff;
   localparam logic [7:0] ERR_MIN_POS      = 8'd4;
   localparam logic [7:0] POS_MAX          = 8'd255;

   localparam logic [7:0]  RST_SHORT_ID   = 8'd16;
   localparam logic [7:0]  RST_LONG_ID    = 8'd17;
   localparam logic [15:0] RST_FEATURE_ID = 16'd6916;
   localparam logic [15:0] RST_CONTROL_ID = 16'd86;

   typedef struct packed {
      logic [7:0]  short_report_id;
      logic [7:0]  long_report_id;
      logic [15:0] feature_id;
      logic [15:0] control_id;
   } cfg_type;

   typedef struct packed {
      logic [2:0] action;
      logic       wanted_flag;
      logic [1:0] sent_kind;
      logic       accepted_flag;
      logic [7:0] report_number;
      logic [7:0] data_byte;
      logic       last_byte;
   } item_type;

   typedef struct packed {
      logic        claims_control;
      logic        control_held;
      logic        press_toggled;
      logic        consumed;
      logic        report_done;
      logic [47:0] command_bytes;
      logic [1:0]  command_kind;
      logic        command_valid;
   } result_type;

endpackage

FILE: hdl/hdcn_csr.sv
`timescale 1ns / 1ps

module hdcn_csr (
   input  logic             clock,
   input  logic             reset,
   input  logic             csr_valid,
   input  logic [7:0]       csr_index,
   input  logic [15:0]      csr_data,
   output hdcn_pkg::cfg_type cfg
);
   import hdcn_pkg::*;

   cfg_type cfg_ff;
   cfg_type cfg_in;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_valid) begin
         case (csr_index)
            CSR_SHORT_ID:   cfg_in.short_report_id = csr_data[7:0];
            CSR_LONG_ID:    cfg_in.long_report_id  = csr_data[7:0];
            CSR_FEATURE_ID: cfg_in.feature_id      = csr_data;
            CSR_CONTROL_ID: cfg_in.control_id      = csr_data;
            default:        cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.short_report_id <= RST_SHORT_ID;
         cfg_ff.long_report_id  <= RST_LONG_ID;
         cfg_ff.feature_id      <= RST_FEATURE_ID;
         cfg_ff.control_id      <= RST_CONTROL_ID;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign cfg = cfg_ff;

endmodule

FILE: hdl/hdcn_core.sv
`timescale 1ns / 1ps

module hdcn_core (
   input  logic                clock,
   input  logic                reset,
   input  logic                step,
   input  hdcn_pkg::item_type  item,
   input  hdcn_pkg::cfg_type   cfg,
   output hdcn_pkg::result_type result
);
   import hdcn_pkg::*;

   typedef struct packed {
      logic        link_up;
      logic        divert_wanted;
      logic        feature_refused;
      logic [7:0]  feature_slot;
      logic [1:0]  awaiting_kind;
      logic        divert_applied;
      logic        pending_on;
      logic        held_state;
      logic [7:0]  byte_position;
      logic [31:0] header_bytes;
      logic [7:0]  id_high_byte;
      logic        id_seen;
      logic        scan_stopped;
   } state_type;

   state_type st_ff;
   state_type st_in;

   function automatic logic error_reply(input logic [7:0] p, input logic [7:0] b1,
                                        input logic [7:0] b2, input logic [7:0] b3,
                                        input logic [7:0] feat, input logic [3:0] fn);
      error_reply = (p >= ERR_MIN_POS) && (b1 == ERR_MARK) && (b2 == feat) &&
                    (b3[7:4] == fn) && (b3[3:0] == SW_ID[3:0]);
   endfunction

   always_comb begin
      logic [7:0]  p;
      logic [1:0]  hdr_idx;
      logic [7:0]  b1;
      logic [7:0]  b2;
      logic [7:0]  b3;
      logic [15:0] cid;
      logic        prior_held;
      logic        now_held;
      logic        taken;

      st_in  = st_ff;
      result = '0;
      p       = st_ff.byte_position;
      hdr_idx = 2'(p - 8'd1);
      b1 = '0;
      b2 = '0;
      b3 = '0;
      cid = '0;
      prior_held = 1'b0;
      now_held = 1'b0;
      taken = 1'b0;

      case (item.action)
         ACT_CONNECT, ACT_DISCONNECT: begin
            st_in = '0;
            st_in.divert_wanted = st_ff.divert_wanted;
            st_in.link_up = (item.action == ACT_CONNECT);
         end
         ACT_SET_WANTED: begin
            if (st_ff.divert_wanted != item.wanted_flag) begin
               st_in.divert_wanted = item.wanted_flag;
               if (item.wanted_flag) st_in.feature_refused = 1'b0;
            end
         end
         ACT_REQUEST: begin
            if (st_ff.link_up && st_ff.awaiting_kind == KIND_NONE) begin
               if (st_ff.feature_slot == 8'd0) begin
                  if (st_ff.divert_wanted && !st_ff.feature_refused) begin
                     result.command_valid = 1'b1;
                     result.command_kind  = KIND_GET;
                     result.command_bytes = {DEV_INDEX, ROOT_INDEX, SW_ID,
                                             cfg.feature_id, 8'd0};
                  end
               end else if (st_ff.divert_applied != st_ff.divert_wanted) begin
                  st_in.pending_on     = st_ff.divert_wanted;
                  result.command_valid = 1'b1;
                  result.command_kind  = KIND_SET;
                  result.command_bytes = {DEV_INDEX, st_ff.feature_slot,
                                          SET_REPORTING_FN, SW_ID[3:0], cfg.control_id,
                                          st_ff.divert_wanted ? FLAGS_ON : FLAGS_OFF};
               end
            end
         end
         ACT_ACCEPTED: begin
            if (item.accepted_flag &&
                (item.sent_kind == KIND_GET || item.sent_kind == KIND_SET))
               st_in.awaiting_kind = item.sent_kind;
         end
         ACT_REPORT: begin
            if (p >= 8'd1 && p <= 8'd4)
               st_in.header_bytes[{hdr_idx, 3'b000} +: 8] = item.data_byte;
            if (!st_ff.scan_stopped && p >= 8'd3) begin
               if (p[0]) begin
                  st_in.id_high_byte = item.data_byte;
               end else begin
                  cid = {st_ff.id_high_byte, item.data_byte};
                  if (cid == 16'd0) st_in.scan_stopped = 1'b1;
                  else if (cid == cfg.control_id) st_in.id_seen = 1'b1;
               end
            end

            if (item.last_byte) begin
               result.report_done = 1'b1;
               b1 = st_in.header_bytes[7:0];
               b2 = st_in.header_bytes[15:8];
               b3 = st_in.header_bytes[23:16];
               if (st_ff.link_up &&
                   (item.report_number == cfg.short_report_id ||
                    item.report_number == cfg.long_report_id) &&
                   (st_ff.divert_wanted || st_ff.divert_applied ||
                    st_ff.awaiting_kind != KIND_NONE || st_ff.feature_slot != 8'd0)) begin
                  result.consumed = 1'b1;
                  if (st_ff.awaiting_kind == KIND_GET) begin
                     if (error_reply(p, b1, b2, b3, ROOT_INDEX, 4'd0)) begin
                        st_in.feature_refused = 1'b1;
                        st_in.awaiting_kind   = KIND_NONE;
                        taken = 1'b1;
                     end else if (p >= 8'd3 && b1 == ROOT_INDEX && b2[7:4] == 4'd0 &&
                                  b2[3:0] == SW_ID[3:0]) begin
                        st_in.feature_slot    = b3;
                        st_in.feature_refused = (b3 == 8'd0);
                        st_in.awaiting_kind   = KIND_NONE;
                        taken = 1'b1;
                     end
                  end
                  if (st_ff.awaiting_kind == KIND_SET) begin
                     if (error_reply(p, b1, b2, b3, st_ff.feature_slot,
                                     SET_REPORTING_FN)) begin
                        if (st_ff.pending_on) begin
                           st_in.feature_refused = 1'b1;
                           st_in.divert_applied  = 1'b0;
                        end
                        st_in.awaiting_kind = KIND_NONE;
                        taken = 1'b1;
                     end else if (p >= 8'd2 && b1 == st_ff.feature_slot &&
                                  b2[7:4] == SET_REPORTING_FN &&
                                  b2[3:0] == SW_ID[3:0]) begin
                        prior_held = st_ff.held_state;
                        st_in.divert_applied = st_ff.pending_on;
                        if (!st_ff.pending_on) st_in.held_state = 1'b0;
                        st_in.awaiting_kind = KIND_NONE;
                        result.press_toggled = (prior_held != st_in.held_state);
                        taken = 1'b1;
                     end
                  end
                  if (!taken && st_ff.feature_slot != 8'd0 && p >= 8'd2 &&
                      b1 == st_ff.feature_slot && b2[7:4] == 4'd0) begin
                     now_held = st_in.id_seen && st_ff.divert_applied;
                     if (now_held != st_ff.held_state) begin
                        st_in.held_state     = now_held;
                        result.press_toggled = 1'b1;
                     end
                  end
               end
               st_in.byte_position = '0;
               st_in.header_bytes  = '0;
               st_in.id_high_byte  = '0;
               st_in.id_seen       = 1'b0;
               st_in.scan_stopped  = 1'b0;
            end else if (st_ff.byte_position < POS_MAX) begin
               st_in.byte_position = st_ff.byte_position + 8'd1;
            end
         end
         default: st_in = st_ff;
      endcase

      result.control_held   = st_in.held_state;
      result.claims_control = st_in.link_up && st_in.divert_applied;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         st_ff <= '0;
      end else if (step) begin
         st_ff <= st_in;
      end
   end

endmodule

FILE: hdl/hid_control_divert_negotiator.sv
`timescale 1ns / 1ps

// Negotiates control diversion with a vendor HID device, one event
// transaction at a time. A transaction is taken every cycle while the rsp
// side is not stalled: it passes through the input register into the event
// logic, whose result loads the result register that offers it on the rsp
// side; that register also holds a result while the rsp side stalls. The
// event logic computes the next protocol state combinationally, so
// back-to-back transactions are handled at full rate when the rsp side does
// not stall. Configuration writes are always accepted and take effect on the next cycle.
module hid_control_divert_negotiator (
   input  logic        clock,
   input  logic        reset,
   // tdata: wanted_flag[0], sent_kind[2:1], accepted_flag[3],
   //        report_number[11:4], data_byte[19:12], zero[23:20]
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [23:0] req_tdata,
   // tuser: action[2:0]
   input  logic [2:0]  req_tuser,
   input  logic        req_tlast,
   // tdata: command_valid[0], command_kind[2:1], command_bytes[50:3],
   //        report_done[51], consumed[52], press_toggled[53],
   //        control_held[54], claims_control[55]
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [55:0] rsp_tdata,
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [7:0]  csr_index,
   input  logic [15:0] csr_data
);
   import hdcn_pkg::*;

   cfg_type    cfg;
   item_type   item_ff;
   item_type   item_in;
   logic       in_valid_ff;
   logic       in_valid_in;
   result_type core_result;
   result_type rsp_ff;
   result_type rsp_in;
   logic       rsp_valid_ff;
   logic       rsp_valid_in;
   logic       advance;
   logic       req_take;

   assign csr_ready  = 1'b1;
   assign advance    = in_valid_ff && (!rsp_valid_ff || rsp_tready);
   assign req_tready = !in_valid_ff || advance;
   assign req_take   = req_tvalid && req_tready;

   always_comb begin
      item_in = item_ff;
      if (req_take) begin
         item_in.action        = req_tuser;
         item_in.wanted_flag   = req_tdata[0];
         item_in.sent_kind     = req_tdata[2:1];
         item_in.accepted_flag = req_tdata[3];
         item_in.report_number = req_tdata[11:4];
         item_in.data_byte     = req_tdata[19:12];
         item_in.last_byte     = req_tlast;
      end
   end

   assign in_valid_in  = req_take || (in_valid_ff && !advance);
   assign rsp_valid_in = advance || (rsp_valid_ff && !rsp_tready);
   assign rsp_in       = advance ? core_result : rsp_ff;

   hdcn_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_valid (csr_valid),
      .csr_index (csr_index),
      .csr_data  (csr_data),
      .cfg       (cfg)
   );

   hdcn_core u_core (
      .clock  (clock),
      .reset  (reset),
      .step   (advance),
      .item   (item_ff),
      .cfg    (cfg),
      .result (core_result)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      item_ff <= item_in;
      rsp_ff  <= rsp_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_ff;

   a_cmd_kind : assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_ff.command_valid |->
         (rsp_ff.command_kind == KIND_GET || rsp_ff.command_kind == KIND_SET))
      else $error("command issued without a kind");

   a_report_fields : assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && !rsp_ff.report_done |-> !rsp_ff.consumed && !rsp_ff.press_toggled)
      else $error("report flags set outside a report end");

   a_advance_loads : assert property (@(posedge clock) disable iff (reset)
      advance |=> rsp_valid_ff)
      else $error("processed transaction lost its result");

   a_no_overrun : assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && !rsp_tready |-> !advance)
      else $error("result register overwritten while stalled");

endmodule
